// File: rtl/core/stk_pkg.sv
package stk_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int ENTRY_WIDTH = 32;

  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int CFG_W  = 9;
  // common width for comparing the fill count with the capacity
  localparam int CAP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(256);

  typedef enum logic [1:0] {
    MODE_PUSH        = 2'd0,
    MODE_POP         = 2'd1,
    MODE_FIND        = 2'd2,
    MODE_PUSH_UNIQUE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_OVF = 2'd1,
    STAT_UNF = 2'd2,
    STAT_DUP = 2'd3
  } status_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [ENTRY_WIDTH-1:0] wdata;
    logic                   re;
    logic [ADDR_W-1:0]      raddr;
  } ram_req_t;

endpackage

// File: rtl/core/stk_ram.sv
module stk_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/stk_ctrl.sv
module stk_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [stk_pkg::CAP_W-1:0]         cap_eff,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic signed [31:0]                in_entry_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_result_value,
  output logic                              out_found,
  output logic [7:0]                        out_found_index,
  output logic [1:0]                        out_status,
  output logic [8:0]                        out_fill_level,
  output stk_pkg::ram_req_t                 ram_req,
  input  logic [stk_pkg::ENTRY_WIDTH-1:0]   ram_rdata
);

  localparam int AW = stk_pkg::ADDR_W;
  localparam int CW = stk_pkg::CNT_W;
  localparam int EW = stk_pkg::ENTRY_WIDTH;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_POP  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  stk_pkg::mode_t        mode_r, mode_nxt;
  logic [EW-1:0]         val_r, val_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [CW-1:0]         scan_addr_r, scan_addr_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [AW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  hit_r, hit_nxt;
  logic [AW-1:0]         hit_idx_r, hit_idx_nxt;
  logic [EW-1:0]         res_val_r, res_val_nxt;
  stk_pkg::status_t      res_stat_r, res_stat_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_result_r, out_result_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [7:0]            out_idx_r, out_idx_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [8:0]            out_fill_r, out_fill_nxt;

  logic [63:0]           in_wide;
  logic [AW+7:0]         idx_ext;
  logic [CW+8:0]         fill_ext;
  logic [EW+31:0]        res_ext;
  logic                  full;
  logic                  load_out;

  // sign-extend the 32-bit word, then keep the stored entry width
  assign in_wide  = {{32{in_entry_value[31]}}, in_entry_value};
  assign idx_ext  = {8'b0, hit_idx_r};
  assign fill_ext = {9'b0, fill_r};
  assign res_ext  = {32'b0, res_val_r};
  assign full     = stk_pkg::CAP_W'(fill_r) >= cap_eff;
  assign in_ready = (state_r == ST_IDLE);
  assign load_out = (state_r == ST_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    val_nxt       = val_r;
    fill_nxt      = fill_r;
    scan_addr_nxt = scan_addr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    res_val_nxt   = res_val_r;
    res_stat_nxt  = res_stat_r;
    ram_req       = '0;
    ram_req.wdata = val_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt     = stk_pkg::mode_t'(in_mode);
          val_nxt      = in_wide[EW-1:0];
          hit_nxt      = 1'b0;
          hit_idx_nxt  = '0;
          res_val_nxt  = '0;
          res_stat_nxt = stk_pkg::STAT_OK;
          case (stk_pkg::mode_t'(in_mode))
            stk_pkg::MODE_PUSH: begin
              if (full) begin
                res_stat_nxt = stk_pkg::STAT_OVF;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = fill_r[AW-1:0];
                ram_req.wdata = in_wide[EW-1:0];
                fill_nxt      = fill_r + CW'(1);
              end
              state_nxt = ST_RESP;
            end
            stk_pkg::MODE_POP: begin
              if (fill_r == '0) begin
                res_stat_nxt = stk_pkg::STAT_UNF;
                state_nxt    = ST_RESP;
              end else begin
                ram_req.re    = 1'b1;
                ram_req.raddr = AW'(fill_r - CW'(1));
                state_nxt     = ST_POP;
              end
            end
            default: begin
              scan_addr_nxt = '0;
              state_nxt     = (fill_r == '0) ? ST_FIN : ST_SCAN;
            end
          endcase
        end
      end
      ST_POP: begin
        res_val_nxt = ram_rdata;
        fill_nxt    = fill_r - CW'(1);
        state_nxt   = ST_RESP;
      end
      ST_SCAN: begin
        // reads run one entry ahead of the compare
        if (scan_addr_r < fill_r) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = scan_addr_r[AW-1:0];
          rd_vld_nxt    = 1'b1;
          rd_idx_nxt    = scan_addr_r[AW-1:0];
          scan_addr_nxt = scan_addr_r + CW'(1);
        end
        if (rd_vld_r && ram_rdata == val_r) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = rd_idx_r;
          state_nxt   = ST_FIN;
        end else if (rd_vld_r && CW'(rd_idx_r) == fill_r - CW'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (mode_r == stk_pkg::MODE_PUSH_UNIQUE) begin
          if (hit_r) begin
            res_stat_nxt = stk_pkg::STAT_DUP;
          end else if (full) begin
            res_stat_nxt = stk_pkg::STAT_OVF;
          end else begin
            ram_req.we    = 1'b1;
            ram_req.waddr = fill_r[AW-1:0];
            fill_nxt      = fill_r + CW'(1);
          end
        end
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_result_nxt = out_result_r;
    out_found_nxt  = out_found_r;
    out_idx_nxt    = out_idx_r;
    out_status_nxt = out_status_r;
    out_fill_nxt   = out_fill_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_result_nxt = res_ext[31:0];
      out_found_nxt  = hit_r;
      out_idx_nxt    = idx_ext[7:0];
      out_status_nxt = res_stat_r;
      out_fill_nxt   = fill_ext[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    val_r        <= val_nxt;
    scan_addr_r  <= scan_addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    res_val_r    <= res_val_nxt;
    res_stat_r   <= res_stat_nxt;
    out_result_r <= out_result_nxt;
    out_found_r  <= out_found_nxt;
    out_idx_r    <= out_idx_nxt;
    out_status_r <= out_status_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_found        = out_found_r;
  assign out_found_index  = out_idx_r;
  assign out_status       = out_status_r;
  assign out_fill_level   = out_fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(stk_pkg::STACK_DEPTH))
    else $error("fill count above stack depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != ST_IDLE))
    else $error("accepted word did not start an operation");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (stk_pkg::CAP_W'(fill_r) < cap_eff))
    else $error("write past capacity");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (fill_r != '0))
    else $error("scan on empty stack");

  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP || state_r == ST_SCAN) |=> $stable(fill_r))
    else $error("fill count changed outside an update state");

endmodule

// File: rtl/core/stack_with_search_and_unique_push.sv
// LIFO stack of signed entries with push, pop, find (lowest matching index)
// and push-if-absent. One word is in work at a time; the result sits in an
// output register, so the next word is taken while it waits. A push goes
// straight to response; a pop's synchronous RAM read lands in the pop
// state; find and push-unique scan one entry per cycle through the single
// RAM read port from index 0, stop at the first match and pass the finish
// state, which an empty stack enters at once. Overflow, underflow and
// duplicates leave the stack unchanged, flagged in status. cfg_data is
// clamped to the stack depth; write it only while the block is idle.
module stack_with_search_and_unique_push (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_entry_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic               out_found,
  output logic [7:0]         out_found_index,
  output logic [1:0]         out_status,
  output logic [8:0]         out_fill_level
);

  logic [stk_pkg::CFG_W-1:0]       cap_r, cap_nxt;
  logic [stk_pkg::CAP_W-1:0]       cap_ext;
  logic [stk_pkg::CAP_W-1:0]       cap_eff;
  stk_pkg::ram_req_t               ram_req;
  logic [stk_pkg::ENTRY_WIDTH-1:0] ram_rdata;

  assign cfg_ready = 1'b1;
  assign cap_nxt   = (cfg_valid && cfg_ready) ? cfg_data : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= stk_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign cap_ext = stk_pkg::CAP_W'(cap_r);
  assign cap_eff = (cap_ext > stk_pkg::CAP_W'(stk_pkg::STACK_DEPTH)) ?
                   stk_pkg::CAP_W'(stk_pkg::STACK_DEPTH) : cap_ext;

  stk_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cap_eff          (cap_eff),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_entry_value   (in_entry_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_found        (out_found),
    .out_found_index  (out_found_index),
    .out_status       (out_status),
    .out_fill_level   (out_fill_level),
    .ram_req          (ram_req),
    .ram_rdata        (ram_rdata)
  );

  stk_ram #(
    .DEPTH  (stk_pkg::STACK_DEPTH),
    .WIDTH  (stk_pkg::ENTRY_WIDTH),
    .ADDR_W (stk_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
